FILE: sv/pcp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcp_pkg: shared types and constants of the point-in-convex-polygon block
// Vertex word layout, operation codes, controller states, cross-product flags.
// ----------------------------------------------------------------------------
package pcp_pkg;

    localparam int MAX_VERTICES_DEF = 256;
    localparam int COORD_W          = 16;
    localparam int COUNT_OUT_W      = 9;
    localparam int OP_W             = 2;

    // x in the low half and y in the high half of the stored word
    typedef struct packed {
        logic signed [COORD_W-1:0] y;
        logic signed [COORD_W-1:0] x;
    } t_point;

    typedef enum logic [OP_W-1:0] {
        OP_CLEAR  = 2'd0,
        OP_APPEND = 2'd1,
        OP_QUERY  = 2'd2
    } t_op;

    typedef enum logic [3:0] {
        S_IDLE,
        S_RD0,
        S_RD1,
        S_RDN,
        S_PAIR,
        S_W1,
        S_W2,
        S_W3,
        S_LOOP,
        S_MIDX,
        S_MIDD,
        S_FIN,
        S_DONE
    } t_state;

    typedef struct packed {
        logic nonneg;
        logic zero;
    } t_cross_flags;

endpackage

FILE: sv/pcp_vmem.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcp_vmem: vertex store
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module pcp_vmem #(
    parameter int DEPTH = pcp_pkg::MAX_VERTICES_DEF,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_wr_en,
    input  logic [AW-1:0]    i_wr_addr,
    input  pcp_pkg::t_point  i_wr_data,
    input  logic [AW-1:0]    i_rd_addr,
    output pcp_pkg::t_point  o_rd_data
);
    import pcp_pkg::*;

    t_point r_mem [DEPTH];
    t_point r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

FILE: sv/pcp_cross.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcp_cross: cross-product sign unit
// Registers (a-b).x*(c-b).y and (c-b).x*(a-b).y, then flags the sign and zero
// of their difference in the following cycle.
// ----------------------------------------------------------------------------
module pcp_cross (
    input  logic                  i_clk,
    input  pcp_pkg::t_point       i_a,
    input  pcp_pkg::t_point       i_b,
    input  pcp_pkg::t_point       i_c,
    output pcp_pkg::t_cross_flags o_flags
);
    import pcp_pkg::*;

    localparam int DW = COORD_W + 1;
    localparam int PW = 2 * DW;

    logic signed [DW-1:0] w_abx, w_cby, w_cbx, w_aby;
    logic signed [PW-1:0] r_p1, r_p2;
    logic signed [PW:0]   w_cr;

    assign w_abx = DW'(i_a.x) - DW'(i_b.x);
    assign w_cby = DW'(i_c.y) - DW'(i_b.y);
    assign w_cbx = DW'(i_c.x) - DW'(i_b.x);
    assign w_aby = DW'(i_a.y) - DW'(i_b.y);

    always_ff @(posedge i_clk) begin
        r_p1 <= w_abx * w_cby;
        r_p2 <= w_cbx * w_aby;
    end

    assign w_cr           = (PW+1)'(r_p1) - (PW+1)'(r_p2);
    assign o_flags.nonneg = ~w_cr[PW];
    assign o_flags.zero   = (w_cr == '0);

endmodule

FILE: sv/point_in_convex_polygon.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// point_in_convex_polygon: vertex store with convex point-inclusion query
// Holds polygon vertices in order; clears, appends, or tests a point.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (i_valid / o_stall): one item per handshake with i_op,
//   i_point_x, i_point_y. Output channel (o_valid / i_stall): one result
//   item per input item with o_inside_res, o_rejected, o_vertex_count.
//   One item is worked on at a time; o_stall is high while it is in flight.
//   The input reopens right after the edge that loads the output register.
//   Clear, append, the unused op code and a query on an empty store go
//   straight to the done state. A query on n >= 3 vertices binary-searches
//   the fan, leaving early when the point falls outside the wedge at
//   vertex 0: each search step costs a read of the vertex memory, one
//   multiply stage of the cross-product unit and a sign decision.
//   The result sits in an output register; the next item is accepted while
//   it waits. If the receiver stalls and a second result is ready, the
//   block holds in its done state until the register drains.
//   Reset (synchronous, active low) empties the store and drops any
//   pending result; stale memory contents never reach a result.
// ----------------------------------------------------------------------------
module point_in_convex_polygon #(
    parameter int MAX_VERTICES = pcp_pkg::MAX_VERTICES_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_valid,
    output logic                              o_stall,
    input  logic [pcp_pkg::OP_W-1:0]          i_op,
    input  logic signed [pcp_pkg::COORD_W-1:0] i_point_x,
    input  logic signed [pcp_pkg::COORD_W-1:0] i_point_y,
    output logic                              o_valid,
    input  logic                              i_stall,
    output logic                              o_inside_res,
    output logic                              o_rejected,
    output logic [pcp_pkg::COUNT_OUT_W-1:0]   o_vertex_count
);
    import pcp_pkg::*;

    localparam int AW    = $clog2(MAX_VERTICES);
    localparam int CNT_W = $clog2(MAX_VERTICES + 1);

    t_state       r_state, n_state;
    logic [CNT_W-1:0] r_count;
    logic [AW-1:0]    r_lo, r_hi, r_mid;
    t_point       r_p, r_f, r_s, r_e, r_c;
    logic         r_inside, r_rej;
    logic         r_out_valid, r_out_inside, r_out_rej;
    logic [COUNT_OUT_W-1:0] r_out_count;

    t_op          w_op;
    logic         w_in_acc;
    logic         w_full;
    logic         w_out_free;
    logic [CNT_W-1:0] w_last;
    logic [AW-1:0]    w_span, w_mid;
    logic         w_more;
    logic         w_bbox;
    logic         w_wr_en;
    logic [AW-1:0]    w_rd_addr;
    t_point       w_rd_data;
    t_point       w_in_pt;
    t_point       w_cr_a, w_cr_b, w_cr_c;
    t_cross_flags w_flags;

    assign w_op       = t_op'(i_op);
    assign w_in_acc   = i_valid && !o_stall;
    assign w_full     = (r_count >= CNT_W'(MAX_VERTICES));
    assign w_out_free = !r_out_valid || !i_stall;
    assign w_last     = r_count - CNT_W'(1);
    assign w_in_pt.x  = i_point_x;
    assign w_in_pt.y  = i_point_y;

    // binary search bounds
    assign w_span = r_hi - r_lo;
    assign w_more = (w_span > AW'(1));
    assign w_mid  = r_lo + (w_span >> 1);

    // closed bounding-box test of the point against the two-vertex segment
    assign w_bbox = ((r_f.x <= r_p.x && r_s.x >= r_p.x) || (r_f.x >= r_p.x && r_s.x <= r_p.x))
                 && ((r_f.y <= r_p.y && r_s.y >= r_p.y) || (r_f.y >= r_p.y && r_s.y <= r_p.y));

    pcp_vmem #(
        .DEPTH (MAX_VERTICES),
        .AW    (AW)
    ) u_vmem (
        .i_clk     (i_clk),
        .i_wr_en   (w_wr_en),
        .i_wr_addr (r_count[AW-1:0]),
        .i_wr_data (w_in_pt),
        .i_rd_addr (w_rd_addr),
        .o_rd_data (w_rd_data)
    );

    pcp_cross u_cross (
        .i_clk   (i_clk),
        .i_a     (w_cr_a),
        .i_b     (w_cr_b),
        .i_c     (w_cr_c),
        .o_flags (w_flags)
    );

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (w_in_acc) begin
                    if (w_op == OP_QUERY && r_count != '0) n_state = S_RD0;
                    else                                   n_state = S_DONE;
                end
            end
            S_RD0:  n_state = S_RD1;
            S_RD1:  n_state = (r_count == CNT_W'(1)) ? S_DONE : S_RDN;
            S_RDN:  n_state = (r_count == CNT_W'(2)) ? S_PAIR : S_W1;
            S_PAIR: n_state = S_DONE;
            S_W1:   n_state = S_W2;
            S_W2:   n_state = w_flags.nonneg ? S_W3 : S_DONE;
            S_W3:   n_state = w_flags.nonneg ? S_LOOP : S_DONE;
            S_LOOP: n_state = w_more ? S_MIDX : S_FIN;
            S_MIDX: n_state = S_MIDD;
            S_MIDD: n_state = S_LOOP;
            S_FIN:  n_state = S_DONE;
            S_DONE: n_state = w_out_free ? S_IDLE : S_DONE;
            default: n_state = S_IDLE;
        endcase
    end

    // state outputs: memory ports, cross-product operands, input stall
    always_comb begin
        o_stall   = 1'b1;
        w_wr_en   = 1'b0;
        w_rd_addr = '0;
        w_cr_a    = r_p;
        w_cr_b    = r_f;
        w_cr_c    = r_e;
        unique case (r_state)
            S_IDLE: begin
                o_stall = 1'b0;
                w_wr_en = w_in_acc && (w_op == OP_APPEND) && !w_full;
            end
            S_RD0: w_rd_addr = '0;
            S_RD1: w_rd_addr = AW'(1);
            S_RDN: begin
                // turn test of the segment for two vertices
                w_rd_addr = w_last[AW-1:0];
                w_cr_a    = w_rd_data;
                w_cr_b    = r_f;
                w_cr_c    = r_p;
            end
            S_W1: begin
                // point left of or on the first fan edge
                w_cr_a = r_s;
                w_cr_b = r_f;
                w_cr_c = r_p;
            end
            S_W2: begin
                // point right of or on the last fan edge
                w_cr_a = r_p;
                w_cr_b = r_f;
                w_cr_c = r_e;
            end
            S_LOOP: begin
                w_rd_addr = w_mid;
                w_cr_a    = r_e;
                w_cr_b    = r_s;
                w_cr_c    = r_p;
            end
            S_MIDX: begin
                w_cr_a = r_p;
                w_cr_b = r_f;
                w_cr_c = w_rd_data;
            end
            default: begin
                o_stall = 1'b1;
            end
        endcase
    end

    // state and vertex count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
        end else begin
            r_state <= n_state;
            if (r_state == S_IDLE && w_in_acc) begin
                unique case (w_op)
                    OP_CLEAR:  r_count <= '0;
                    OP_APPEND: if (!w_full) r_count <= r_count + CNT_W'(1);
                    default:   r_count <= r_count;
                endcase
            end
        end
    end

    // query datapath
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                if (w_in_acc) begin
                    r_p      <= w_in_pt;
                    r_inside <= 1'b0;
                    r_rej    <= (w_op == OP_APPEND) && w_full;
                end
            end
            S_RD0: begin
                r_lo <= AW'(1);
                r_hi <= w_last[AW-1:0];
            end
            S_RD1: begin
                r_f      <= w_rd_data;
                r_inside <= (w_rd_data == r_p);
            end
            S_RDN:  r_s      <= w_rd_data;
            S_PAIR: r_inside <= w_flags.zero && w_bbox;
            S_W1:   r_e      <= w_rd_data;
            S_LOOP: r_mid    <= w_mid;
            S_MIDX: r_c      <= w_rd_data;
            S_MIDD: begin
                // advance the low bound when the point lies past this spoke
                if (!w_flags.nonneg) begin
                    r_lo <= r_mid;
                    r_s  <= r_c;
                end else begin
                    r_hi <= r_mid;
                    r_e  <= r_c;
                end
            end
            S_FIN:  r_inside <= w_flags.nonneg;
            default: begin
                r_inside <= r_inside;
            end
        endcase
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (r_state == S_DONE && w_out_free) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_DONE && w_out_free) begin
            r_out_inside <= r_inside;
            r_out_rej    <= r_rej;
            r_out_count  <= COUNT_OUT_W'(r_count);
        end
    end

    assign o_valid        = r_out_valid;
    assign o_inside_res   = r_out_inside;
    assign o_rejected     = r_out_rej;
    assign o_vertex_count = r_out_count;

endmodule

FILE: sv/pcp_chk.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcp_chk: port-level checker for point_in_convex_polygon
// Watches both channels and the result fields over time.
// ----------------------------------------------------------------------------
module pcp_chk #(
    parameter int MAX_VERTICES = pcp_pkg::MAX_VERTICES_DEF
) (
    input logic                              i_clk,
    input logic                              i_rst_n,
    input logic                              i_valid,
    input logic                              o_stall,
    input logic                              o_valid,
    input logic                              i_stall,
    input logic                              o_inside_res,
    input logic                              o_rejected,
    input logic [pcp_pkg::COUNT_OUT_W-1:0]   o_vertex_count
);
    import pcp_pkg::*;

    // hold a stalled result
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_inside_res)
            && $stable(o_rejected) && $stable(o_vertex_count))
        else $error("stalled result changed");

    // one item in flight: input closes after an acceptance
    a_one: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_stall |=> o_stall)
        else $error("input reopened right after acceptance");

    // a rejected append reports a full store and no inclusion
    a_rej: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_rejected |->
            o_vertex_count == COUNT_OUT_W'(MAX_VERTICES) && !o_inside_res)
        else $error("rejection without full store");

    // drop pending results at reset
    a_rst: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result survived reset");

endmodule

bind point_in_convex_polygon pcp_chk #(
    .MAX_VERTICES (MAX_VERTICES)
) u_pcp_chk (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_valid        (i_valid),
    .o_stall        (o_stall),
    .o_valid        (o_valid),
    .i_stall        (i_stall),
    .o_inside_res   (o_inside_res),
    .o_rejected     (o_rejected),
    .o_vertex_count (o_vertex_count)
);
